// ===== hw/rtl/mavg_pkg.sv =====
package mavg_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int THR_W      = 15;
	localparam int TALLY_W    = 16;
	localparam int WINDOW_DEF = 7;
	localparam int ADDR_W     = 3;
	localparam int DATA_W     = 32;

	localparam logic [THR_W-1:0] THR_RESET = THR_W'(1280);

	typedef enum logic {
		REG_THRESHOLD = 1'b0
	} reg_index_t;

	typedef struct packed {
		logic mean_valid;
		logic last;
	} item_ctl_t;

endpackage

// ===== hw/rtl/mavg_cell.sv =====
module mavg_cell (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 shift_en,
	input  logic                                 clear,
	input  logic signed [mavg_pkg::SAMPLE_W-1:0] din,
	input  logic                                 occ_in,
	output logic signed [mavg_pkg::SAMPLE_W-1:0] dout,
	output logic                                 occ_out
);

	logic signed [mavg_pkg::SAMPLE_W-1:0] data_q;
	logic                                 occ_q;

	always_ff @(posedge clk) begin
		if (shift_en) begin
			data_q <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
		end else if (shift_en) begin
			occ_q <= clear ? 1'b0 : occ_in;
		end
	end

	assign dout    = data_q;
	assign occ_out = occ_q;

endmodule

// ===== hw/rtl/mavg_eval.sv =====
module mavg_eval #(
	parameter int WINDOW = mavg_pkg::WINDOW_DEF,
	parameter int SUM_W  = mavg_pkg::SAMPLE_W + $clog2(WINDOW)
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_vld,
	output logic                                 in_rdy,
	input  logic signed [mavg_pkg::SAMPLE_W-1:0] sample_in,
	input  logic signed [SUM_W-1:0]              total_in,
	input  mavg_pkg::item_ctl_t                  ctl_in,
	input  logic [mavg_pkg::THR_W-1:0]           threshold,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [mavg_pkg::SAMPLE_W-1:0] window_mean,
	output logic                                 mean_valid,
	output logic                                 anomaly,
	output logic [mavg_pkg::TALLY_W-1:0]         anomaly_total,
	output logic                                 set_done
);

	localparam int DEV_W   = SUM_W + 1;
	localparam int SH      = SUM_W + $clog2(WINDOW);
	localparam int RECIP_W = SUM_W + 1;
	localparam int PROD_W  = SUM_W + RECIP_W;
	localparam int RECIP   = ((1 << SH) + WINDOW - 1) / WINDOW;

	localparam logic signed [DEV_W-1:0] WIN_S   = DEV_W'(WINDOW);
	localparam logic [DEV_W-1:0]        WIN_U   = DEV_W'(WINDOW);
	localparam logic [RECIP_W-1:0]      RECIP_U = RECIP_W'(RECIP);

	logic                          adv2;
	logic                          adv3;
	logic signed [DEV_W-1:0]       scaled;
	logic signed [DEV_W-1:0]       dev;
	logic [DEV_W-1:0]              dev_abs;
	logic [DEV_W-1:0]              limit;
	logic                          neg;
	logic [SUM_W-1:0]              total_abs;
	logic                          anom;
	logic [mavg_pkg::TALLY_W-1:0]  tally_nxt;
	logic [mavg_pkg::SAMPLE_W-1:0] quot;

	logic                          vld_s2;
	logic [PROD_W-1:0]             prod_s2;
	logic                          neg_s2;
	mavg_pkg::item_ctl_t           ctl_s2;
	logic                          anom_s2;
	logic [mavg_pkg::TALLY_W-1:0]  tally_s2;
	logic [mavg_pkg::TALLY_W-1:0]  tally_q;

	logic                                 vld_s3;
	logic signed [mavg_pkg::SAMPLE_W-1:0] mean_s3;
	logic                                 mean_valid_s3;
	logic                                 anom_s3;
	logic [mavg_pkg::TALLY_W-1:0]         tally_s3;
	logic                                 last_s3;

	assign adv3   = !vld_s3 || out_ready;
	assign adv2   = !vld_s2 || adv3;
	assign in_rdy = adv2;

	always_comb begin
		scaled    = DEV_W'(sample_in) * WIN_S;
		dev       = scaled - DEV_W'(total_in);
		dev_abs   = dev[DEV_W-1] ? DEV_W'(-dev) : DEV_W'(dev);
		limit     = DEV_W'(threshold) * WIN_U;
		neg       = total_in[SUM_W-1];
		total_abs = neg ? SUM_W'(-total_in) : SUM_W'(total_in);
		anom      = ctl_in.mean_valid && (dev_abs > limit);
		tally_nxt = (anom && (tally_q != '1)) ? tally_q + 1'b1 : tally_q;
		quot      = prod_s2[SH +: mavg_pkg::SAMPLE_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			tally_q <= '0;
		end else begin
			if (adv2) begin
				vld_s2 <= in_vld;
			end
			if (adv3) begin
				vld_s3 <= vld_s2;
			end
			if (in_vld && adv2) begin
				tally_q <= ctl_in.last ? '0 : tally_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_vld && adv2) begin
			prod_s2  <= PROD_W'(total_abs) * PROD_W'(RECIP_U);
			neg_s2   <= neg;
			ctl_s2   <= ctl_in;
			anom_s2  <= anom;
			tally_s2 <= tally_nxt;
		end
		if (vld_s2 && adv3) begin
			if (!ctl_s2.mean_valid) begin
				mean_s3 <= '0;
			end else begin
				mean_s3 <= neg_s2 ? -$signed(quot) : $signed(quot);
			end
			mean_valid_s3 <= ctl_s2.mean_valid;
			anom_s3       <= anom_s2;
			tally_s3      <= tally_s2;
			last_s3       <= ctl_s2.last;
		end
	end

	assign out_valid     = vld_s3;
	assign window_mean   = mean_s3;
	assign mean_valid    = mean_valid_s3;
	assign anomaly       = anom_s3;
	assign anomaly_total = tally_s3;
	assign set_done      = last_s3;

endmodule

// ===== hw/rtl/moving_average_anomaly_counter_core.sv =====
// Channel   Direction  Handshake             Payload
// input     in         in_valid / in_ready   sample, end_of_set
// output    out        out_valid / out_ready window_mean, mean_valid, anomaly,
//                                            anomaly_total, set_done
// config    in         APB, pready high      deviation_threshold at byte 0
//
// One item is accepted per cycle unless out_ready stalls; results pass s1, s2, s3.
// The rate is set by the running-sum update at intake, which shifts the sample cells.
// Stages hold items while the next is full and held; bubbles fill under a stall.
// Reset clears the sum, the tally, the cell occupancy and all valid bits at once.
module moving_average_anomaly_counter_core #(
	parameter int WINDOW = mavg_pkg::WINDOW_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [mavg_pkg::ADDR_W-1:0]          paddr,
	input  logic [mavg_pkg::DATA_W-1:0]          pwdata,
	output logic [mavg_pkg::DATA_W-1:0]          prdata,
	output logic                                 pready,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [mavg_pkg::SAMPLE_W-1:0] sample,
	input  logic                                 end_of_set,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [mavg_pkg::SAMPLE_W-1:0] window_mean,
	output logic                                 mean_valid,
	output logic                                 anomaly,
	output logic [mavg_pkg::TALLY_W-1:0]         anomaly_total,
	output logic                                 set_done
);

	localparam int SUM_W = mavg_pkg::SAMPLE_W + $clog2(WINDOW);

	logic signed [mavg_pkg::SAMPLE_W-1:0] cell_data [WINDOW];
	logic                                 cell_occ  [WINDOW];

	logic [mavg_pkg::THR_W-1:0] thr_q;
	logic                       reg_sel;
	logic                       shift;
	logic                       adv1;
	logic                       eval_rdy;
	logic signed [SUM_W-1:0]    oldest;
	logic signed [SUM_W-1:0]    new_total;
	logic signed [SUM_W-1:0]    total_q;

	logic                                 vld_s1;
	logic signed [mavg_pkg::SAMPLE_W-1:0] sample_s1;
	logic signed [SUM_W-1:0]              total_s1;
	mavg_pkg::item_ctl_t                  ctl_s1;

	assign pready  = 1'b1;
	assign reg_sel = (paddr[2] == mavg_pkg::REG_THRESHOLD);
	assign prdata  = reg_sel ? mavg_pkg::DATA_W'(thr_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= mavg_pkg::THR_RESET;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			thr_q <= pwdata[mavg_pkg::THR_W-1:0];
		end
	end

	assign adv1     = !vld_s1 || eval_rdy;
	assign in_ready = adv1;
	assign shift    = in_valid && adv1;

	for (genvar i = 0; i < WINDOW; i++) begin : g_cell
		if (i == 0) begin : g_head
			mavg_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.shift_en (shift),
				.clear    (end_of_set),
				.din      (sample),
				.occ_in   (1'b1),
				.dout     (cell_data[i]),
				.occ_out  (cell_occ[i])
			);
		end else begin : g_body
			mavg_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.shift_en (shift),
				.clear    (end_of_set),
				.din      (cell_data[i-1]),
				.occ_in   (cell_occ[i-1]),
				.dout     (cell_data[i]),
				.occ_out  (cell_occ[i])
			);
		end
	end

	always_comb begin
		oldest    = cell_occ[WINDOW-1] ? SUM_W'(cell_data[WINDOW-1]) : '0;
		new_total = total_q - oldest + SUM_W'(sample);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			vld_s1  <= 1'b0;
		end else begin
			if (shift) begin
				total_q <= end_of_set ? '0 : new_total;
			end
			if (adv1) begin
				vld_s1 <= in_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			sample_s1         <= sample;
			total_s1          <= new_total;
			ctl_s1.mean_valid <= cell_occ[WINDOW-2];
			ctl_s1.last       <= end_of_set;
		end
	end

	mavg_eval #(
		.WINDOW (WINDOW),
		.SUM_W  (SUM_W)
	) u_eval (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_vld        (vld_s1),
		.in_rdy        (eval_rdy),
		.sample_in     (sample_s1),
		.total_in      (total_s1),
		.ctl_in        (ctl_s1),
		.threshold     (thr_q),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.window_mean   (window_mean),
		.mean_valid    (mean_valid),
		.anomaly       (anomaly),
		.anomaly_total (anomaly_total),
		.set_done      (set_done)
	);

endmodule

// ===== hw/rtl/mavg_checker.sv =====
module mavg_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 out_valid,
	input logic                                 out_ready,
	input logic signed [mavg_pkg::SAMPLE_W-1:0] window_mean,
	input logic                                 mean_valid,
	input logic                                 anomaly,
	input logic [mavg_pkg::TALLY_W-1:0]         anomaly_total,
	input logic                                 set_done
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(window_mean) &&
			$stable(anomaly_total) && $stable(mean_valid) && $stable(set_done))
		else $error("Result item changed while stalled.");

	a_anom_needs_mean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && anomaly |-> mean_valid)
		else $error("Anomaly flagged without a full window.");

	a_unfilled_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !mean_valid |-> window_mean == '0 && anomaly_total == '0)
		else $error("Unfilled window reports a mean or a count.");

	a_tally_steps: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !set_done ##1 out_valid && anomaly &&
			$past(anomaly_total) != '1 && $past(mean_valid)
			|-> anomaly_total == $past(anomaly_total) + 1'b1)
		else $error("Anomaly count did not advance.");

endmodule

bind moving_average_anomaly_counter_core mavg_checker u_mavg_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.window_mean   (window_mean),
	.mean_valid    (mean_valid),
	.anomaly       (anomaly),
	.anomaly_total (anomaly_total),
	.set_done      (set_done)
);
